>>> hdl/vrpc_pkg.sv
`default_nettype none
package vrpc_pkg;

    localparam int RATE_W   = 16;
    localparam int POS_W    = 31;
    localparam int FRAME_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int ERR_W    = 3;
    localparam int SEEK_W   = 32;
    localparam int WIDE_W   = 64;
    localparam int MCNT_W   = 6;
    localparam int OUT_W    = 88;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;
    localparam logic [POS_W-1:0]  POS_MAX    = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        F_CLEAR  = 3'd0,
        F_APPEND = 3'd1,
        F_PLAY   = 3'd2,
        F_PAUSE  = 3'd3,
        F_SPEED  = 3'd4,
        F_LOOP   = 3'd5,
        F_SEEK   = 3'd6,
        F_QUERY  = 3'd7
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        E_OK        = 3'd0,
        E_BAD_SPEED = 3'd1,
        E_DECREASE  = 3'd2,
        E_FULL      = 3'd3,
        E_RANGE     = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_ELAPSED,
        S_MUL,
        S_SUM,
        S_FIX,
        S_MOD,
        S_REBASE,
        S_SRD,
        S_SCMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
        logic elapsed;
        logic mul;
        logic sum;
        logic fix;
        logic mod_step;
        logic rebase;
        logic srch_cmp;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_need;
        logic mod_last;
        logic srch_busy;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> hdl/variable_rate_playback_clock.sv
// Playback clock: one command per transaction, one result per command.
// Each command passes through the apply, elapsed, multiply, sum and fix steps,
// the bit-serial remainder unit when a looping position wraps, and a binary
// search of up to log2(TIMELINE_DEPTH)+1 steps. Commands are handled one at a
// time; the next is accepted once the result is in the output register.
// Reset (synchronous, active low) empties the timeline, stops, speed one.
`default_nettype none
module variable_rate_playback_clock import vrpc_pkg::*; #(
    parameter int TIMELINE_DEPTH  = 1024,
    parameter int SPEED_FRAC_BITS = 8,
    parameter int TIME_BITS       = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // time_now_us, timestamp_us, speed_q8, loop_enable, seek_target_us, zero pad
    input  wire logic [((2*TIME_BITS+RATE_W+1+SEEK_W+7)/8)*8-1:0] i_s_tdata,
    // func
    input  wire logic [2:0] i_s_tuser,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // position_us, frame_index, at_end, is_playing, duration_us, entry_count,
    // error_code
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int IN_TW = ((2 * TIME_BITS + RATE_W + 1 + SEEK_W + 7) / 8) * 8;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    vrpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vrpc_dp #(
        .TIMELINE_DEPTH  (TIMELINE_DEPTH),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .TIME_BITS       (TIME_BITS),
        .IN_TW           (IN_TW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

>>> hdl/vrpc_ram.sv
`default_nettype none
module vrpc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hdl/vrpc_ctrl.sv
`default_nettype none
module vrpc_ctrl import vrpc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no transaction is taken while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_ELAPSED;
            end
            S_ELAPSED: begin
                o_cmd.elapsed = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = i_stat.mod_need ? S_MOD : S_REBASE;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_REBASE;
                end
            end
            S_REBASE: begin
                o_cmd.rebase = 1'b1;
                n_state      = S_SRD;
            end
            S_SRD: begin
                n_state = i_stat.srch_busy ? S_SCMP : S_OUT;
            end
            S_SCMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = S_SRD;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/vrpc_dp.sv
`default_nettype none
module vrpc_dp import vrpc_pkg::*; #(
    parameter int TIMELINE_DEPTH  = 1024,
    parameter int SPEED_FRAC_BITS = 8,
    parameter int TIME_BITS       = 48,
    parameter int IN_TW           = 152
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    input  wire logic [IN_TW-1:0] i_s_tdata,
    input  wire logic [2:0]       i_s_tuser,
    input  wire logic             i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_W-1:0]      o_m_tdata
);

    localparam int AW    = $clog2(TIMELINE_DEPTH);
    localparam int CW    = $clog2(TIMELINE_DEPTH + 1);
    localparam int PW    = TIME_BITS + RATE_W;
    localparam int O_TS  = TIME_BITS;
    localparam int O_SPD = 2 * TIME_BITS;
    localparam int O_LP  = O_SPD + RATE_W;
    localparam int O_SK  = O_LP + 1;

    // captured command
    t_func                 r_func;
    logic [TIME_BITS-1:0]  r_now, r_ts;
    logic [RATE_W-1:0]     r_spd;
    logic                  r_loop;
    logic [SEEK_W-1:0]     r_seek;

    // architectural state
    logic [CW-1:0]         r_count, n_count;
    logic [TIME_BITS-1:0]  r_first, n_first;
    logic                  r_running, n_running;
    logic [POS_W-1:0]      r_held, n_held;
    logic [TIME_BITS-1:0]  r_anchor, n_anchor;
    logic [RATE_W-1:0]     r_rate, n_rate;
    logic                  r_wrap, n_wrap;
    logic [POS_W-1:0]      r_dur, n_dur;
    logic                  r_rebase, n_rebase;
    t_err                  r_err, n_err;

    // working registers
    logic [TIME_BITS-1:0]  r_elapsed;
    logic [PW-1:0]         r_prod;
    logic [WIDE_W-1:0]     r_cur;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_rem;
    logic [WIDE_W-1:0]     r_quo;
    logic [MCNT_W-1:0]     r_mcnt;
    logic [CW-1:0]         r_lo, r_hi;
    logic                  r_ovalid;
    logic [OUT_W-1:0]      r_odata;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [POS_W-1:0]      wdata;
    logic [POS_W-1:0]      rdata;
    logic [TIME_BITS-1:0]  rel;
    logic [CW-1:0]         mid;
    logic [PW+WIDE_W-1:0]  prod_ext;
    logic                  prod_ovf;
    logic [WIDE_W-1:0]     prod64;
    logic [WIDE_W:0]       sum;
    logic                  cur_gt;
    logic [POS_W:0]        trial;
    logic [POS_W:0]        rem_n;
    logic [CW-1:0]         frame;
    logic                  at_end;

    assign rel = r_ts - r_first;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    vrpc_ram #(
        .WIDTH (POS_W),
        .DEPTH (TIMELINE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (mid[AW-1:0]),
        .o_rdata (rdata)
    );

    // command decode and state update
    always_comb begin
        n_count   = r_count;
        n_first   = r_first;
        n_running = r_running;
        n_held    = r_held;
        n_anchor  = r_anchor;
        n_rate    = r_rate;
        n_wrap    = r_wrap;
        n_dur     = r_dur;
        n_rebase  = r_rebase;
        n_err     = r_err;
        we        = 1'b0;
        waddr     = r_count[AW-1:0];
        wdata     = rel[POS_W-1:0];
        if (i_cmd.apply) begin
            n_err    = E_OK;
            n_rebase = 1'b0;
            case (r_func)
                F_CLEAR: begin
                    n_count   = '0;
                    n_first   = '0;
                    n_dur     = '0;
                    n_running = 1'b0;
                    n_held    = '0;
                    n_anchor  = '0;
                end
                F_APPEND: begin
                    if (r_count >= CW'(TIMELINE_DEPTH)) begin
                        n_err = E_FULL;
                    end else if (r_count == '0) begin
                        n_first   = r_ts;
                        we        = 1'b1;
                        wdata     = '0;
                        n_count   = CW'(1);
                        n_dur     = '0;
                        n_running = 1'b0;
                        n_held    = '0;
                        n_anchor  = '0;
                    end else if (r_ts < r_first) begin
                        n_err = E_DECREASE;
                    end else if (rel < TIME_BITS'(r_dur)) begin
                        n_err = E_DECREASE;
                    end else if (rel > TIME_BITS'(POS_MAX)) begin
                        n_err = E_RANGE;
                    end else begin
                        we        = 1'b1;
                        n_count   = r_count + CW'(1);
                        n_dur     = rel[POS_W-1:0];
                        n_running = 1'b0;
                        n_held    = '0;
                        n_anchor  = '0;
                    end
                end
                F_PLAY: begin
                    if (!r_running && r_count != '0) begin
                        n_anchor  = r_now;
                        n_running = 1'b1;
                    end
                end
                F_PAUSE: begin
                    n_rebase = r_running;
                end
                F_SPEED: begin
                    if (r_spd == '0) begin
                        n_err = E_BAD_SPEED;
                    end else if (r_running) begin
                        n_rebase = 1'b1;
                    end else begin
                        n_rate = r_spd;
                    end
                end
                F_LOOP: begin
                    if (r_running) begin
                        n_rebase = 1'b1;
                    end else begin
                        n_wrap = r_loop;
                    end
                end
                F_SEEK: begin
                    if (r_seek[SEEK_W-1]) begin
                        n_held = '0;
                    end else if (r_seek[POS_W-1:0] > r_dur) begin
                        n_held = r_dur;
                    end else begin
                        n_held = r_seek[POS_W-1:0];
                    end
                    n_anchor = r_now;
                end
                default: begin
                end
            endcase
        end
        // running commands: position is taken before the change
        if (i_cmd.rebase && r_rebase) begin
            n_held = r_pos;
            case (r_func)
                F_PAUSE: n_running = 1'b0;
                F_SPEED: begin
                    n_anchor = r_now;
                    n_rate   = r_spd;
                end
                F_LOOP: begin
                    n_anchor = r_now;
                    n_wrap   = r_loop;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_first   <= '0;
            r_running <= 1'b0;
            r_held    <= '0;
            r_anchor  <= '0;
            r_rate    <= RATE_RESET;
            r_wrap    <= 1'b0;
            r_dur     <= '0;
            r_rebase  <= 1'b0;
            r_err     <= E_OK;
            r_ovalid  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_first   <= n_first;
            r_running <= n_running;
            r_held    <= n_held;
            r_anchor  <= n_anchor;
            r_rate    <= n_rate;
            r_wrap    <= n_wrap;
            r_dur     <= n_dur;
            r_rebase  <= n_rebase;
            r_err     <= n_err;
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // position arithmetic
    assign prod_ext = (PW + WIDE_W)'(r_prod);
    assign prod_ovf = |(prod_ext >> WIDE_W);
    assign prod64   = prod_ovf ? '1 : prod_ext[WIDE_W-1:0];
    assign sum      = {1'b0, prod64 >> SPEED_FRAC_BITS} + (WIDE_W + 1)'(r_held);
    assign cur_gt   = r_cur > WIDE_W'(r_dur);
    assign trial    = {r_rem, r_quo[WIDE_W-1]};
    assign rem_n    = (trial >= {1'b0, r_dur}) ? trial - {1'b0, r_dur} : trial;
    assign frame    = (r_lo == '0) ? '0 : r_lo - CW'(1);
    assign at_end   = (r_count != '0) && !r_wrap && (r_pos >= r_dur);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_s_tuser);
            r_now  <= i_s_tdata[TIME_BITS-1:0];
            r_ts   <= i_s_tdata[O_TS +: TIME_BITS];
            r_spd  <= i_s_tdata[O_SPD +: RATE_W];
            r_loop <= i_s_tdata[O_LP];
            r_seek <= i_s_tdata[O_SK +: SEEK_W];
        end
        if (i_cmd.elapsed) begin
            r_elapsed <= (r_running && r_now > r_anchor) ? r_now - r_anchor : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_elapsed) * PW'(r_rate);
        end
        if (i_cmd.sum) begin
            r_cur <= sum[WIDE_W] ? '1 : sum[WIDE_W-1:0];
        end
        if (i_cmd.fix) begin
            if (r_count == '0) begin
                r_pos <= '0;
            end else if (cur_gt) begin
                r_pos <= r_dur;
            end else begin
                r_pos <= r_cur[POS_W-1:0];
            end
            r_quo  <= r_cur;
            r_rem  <= '0;
            r_mcnt <= '0;
        end
        // restoring remainder, one dividend bit per cycle
        if (i_cmd.mod_step) begin
            r_rem  <= rem_n[POS_W-1:0];
            r_quo  <= r_quo << 1;
            r_mcnt <= r_mcnt + MCNT_W'(1);
            if (&r_mcnt) begin
                r_pos <= rem_n[POS_W-1:0];
            end
        end
        if (i_cmd.rebase) begin
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmd.srch_cmp) begin
            if (rdata <= r_pos) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.load_out) begin
            r_odata <= {r_err,
                        COUNT_W'(32'(r_count)),
                        r_dur,
                        r_running,
                        at_end,
                        FRAME_W'(32'(frame)),
                        r_pos};
        end
    end

    assign o_stat.mod_need  = r_wrap && (r_dur != '0) && cur_gt && (r_count != '0);
    assign o_stat.mod_last  = &r_mcnt;
    assign o_stat.srch_busy = r_lo < r_hi;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import vrpc_pkg::*;

    localparam int DEPTH = 1024;
    localparam int IN_W  = 152;

    typedef struct {
        t_func       fn;
        logic [47:0] now;
        logic [47:0] ts;
        logic [15:0] spd;
        logic        lp;
        logic [31:0] seek;
        bit          drain;
    } cmd_t;

    // packed from the top bit down to match o_m_tdata
    typedef struct packed {
        logic [2:0]  err;
        logic [10:0] count;
        logic [30:0] dur;
        logic        playing;
        logic        at_end;
        logic [9:0]  frame;
        logic [30:0] pos;
    } status_t;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              s_tvalid = 0;
    logic              o_s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [2:0]        s_tuser = '0;
    logic              o_m_tvalid;
    logic              m_tready = 0;
    logic [OUT_W-1:0]  o_m_tdata;

    variable_rate_playback_clock u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(m_tready), .o_m_tdata(o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    cmd_t    cmd_q[$];
    status_t status_q[$];
    int      errors = 0;
    int      accepted = 0;
    int      results = 0;
    int      hold_off = 0;
    bit      hold_done = 0;

    // playback state mirror
    logic [30:0] tl[DEPTH];
    logic [10:0] n_loaded;
    logic [47:0] first_ts;
    logic        running;
    logic [30:0] held;
    logic [47:0] anchor;
    logic [15:0] rate;
    logic        wrap;

    function automatic int idle_pct();
        case ((accepted / 150) % 4)
            0: return 0;
            1: return 55;
            2: return 0;
            default: return 33;
        endcase
    endfunction

    function automatic int stall_pct();
        case ((accepted / 150) % 4)
            0: return 0;
            1: return 0;
            2: return 55;
            default: return 33;
        endcase
    endfunction

    function automatic logic [30:0] span();
        return n_loaded == 0 ? 31'd0 : tl[n_loaded - 1];
    endfunction

    function automatic logic [30:0] position_at(logic [47:0] now);
        logic [63:0] cur;
        logic [63:0] dur;
        if (n_loaded == 0) return '0;
        cur = held;
        if (running && now > anchor)
            cur = cur + (((64'(now - anchor)) * rate) >> 8);
        dur = span();
        if (wrap && dur > 0 && cur > dur) cur = cur % dur;
        else if (cur > dur) cur = dur;
        return cur[30:0];
    endfunction

    function automatic logic [9:0] frame_of(logic [30:0] pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n_loaded;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tl[mid] <= pos) lo = mid + 1;
            else hi = mid;
        end
        return lo == 0 ? 10'd0 : 10'(lo - 1);
    endfunction

    task automatic halt_playback();
        running = 0;
        held = '0;
        anchor = '0;
    endtask

    task automatic apply_command(cmd_t c);
        t_err        e;
        logic [63:0] rel;
        logic [30:0] pos;
        status_t     s;
        e = E_OK;
        case (c.fn)
            F_CLEAR: begin
                n_loaded = 0;
                first_ts = 0;
                halt_playback();
            end
            F_APPEND: begin
                if (n_loaded >= DEPTH) begin
                    e = E_FULL;
                end else if (n_loaded == 0) begin
                    first_ts = c.ts;
                    tl[0] = '0;
                    n_loaded = 1;
                    halt_playback();
                end else if (c.ts < first_ts) begin
                    e = E_DECREASE;
                end else begin
                    rel = 64'(c.ts - first_ts);
                    if (rel < tl[n_loaded - 1]) e = E_DECREASE;
                    else if (rel > POS_MAX) e = E_RANGE;
                    else begin
                        tl[n_loaded] = rel[30:0];
                        n_loaded++;
                        halt_playback();
                    end
                end
            end
            F_PLAY: if (!running && n_loaded != 0) begin
                anchor = c.now;
                running = 1;
            end
            F_PAUSE: if (running) begin
                held = position_at(c.now);
                running = 0;
            end
            F_SPEED: begin
                if (c.spd == 0) e = E_BAD_SPEED;
                else begin
                    if (running) begin
                        held = position_at(c.now);
                        anchor = c.now;
                    end
                    rate = c.spd;
                end
            end
            F_LOOP: begin
                if (running) begin
                    held = position_at(c.now);
                    anchor = c.now;
                end
                wrap = c.lp;
            end
            F_SEEK: begin
                if (c.seek[31]) held = '0;
                else held = (c.seek > span()) ? span() : c.seek[30:0];
                anchor = c.now;
            end
            default: ;
        endcase
        pos = position_at(c.now);
        s.pos = pos;
        s.frame = n_loaded == 0 ? 10'd0 : frame_of(pos);
        s.at_end = n_loaded != 0 && !wrap && pos >= span();
        s.playing = running;
        s.dur = span();
        s.count = n_loaded;
        s.err = e;
        status_q.insert(status_q.size(), s);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h", results, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(s_tvalid && !o_s_tready)) begin
                if (s_tvalid) begin
                    apply_command(cmd_q.pop_front());
                    accepted++;
                end
                if (cmd_q.size() != 0 && !(cmd_q[0].drain && status_q.size() != 0)
                        && $urandom_range(99) >= idle_pct()) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= cmd_q[0].fn;
                    s_tdata <= {7'd0, cmd_q[0].seek, cmd_q[0].lp, cmd_q[0].spd,
                                cmd_q[0].ts, cmd_q[0].now};
                    cmd_q[0].drain = 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        status_t g;
        status_t w;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                g = o_m_tdata;
                results++;
                if (status_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(results), 64'(0));
                end else begin
                    w = status_q.pop_front();
                    if (g.pos !== w.pos) report_mismatch("position_us", g.pos, w.pos);
                    if (g.frame !== w.frame) report_mismatch("frame_index", g.frame, w.frame);
                    if (g.at_end !== w.at_end) report_mismatch("at_end", g.at_end, w.at_end);
                    if (g.playing !== w.playing)
                        report_mismatch("is_playing", g.playing, w.playing);
                    if (g.dur !== w.dur) report_mismatch("duration_us", g.dur, w.dur);
                    if (g.count !== w.count) report_mismatch("entry_count", g.count, w.count);
                    if (g.err !== w.err) report_mismatch("error_code", g.err, w.err);
                end
            end
        end
    end

    // receiver ready, with one long hold-off while commands keep coming
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && results == 300) begin
                hold_done = 1;
                hold_off = 400;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct());
            end
        end
    end

    logic [47:0] wall;
    logic [47:0] last_ts;

    function automatic logic [47:0] tick();
        case ($urandom_range(19))
            0: wall = wall - $urandom_range(3000);          // clock goes backwards
            1: wall = 48'({$urandom, $urandom});
            2: wall = wall + 48'({$urandom_range(255), 32'd0});  // huge elapsed time
            default: wall = wall + $urandom_range(5000);
        endcase
        return wall;
    endfunction

    task automatic put(t_func fn, logic [47:0] ts = '0, logic [15:0] spd = 16'd256,
                       logic lp = 0, logic [31:0] seek = '0, bit drain = 0);
        cmd_t c;
        c.fn = fn;
        c.now = tick();
        c.ts = ts;
        c.spd = spd;
        c.lp = lp;
        c.seek = seek;
        c.drain = drain;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic put_noise();
        cmd_t c;
        c.fn = t_func'($urandom_range(7));
        c.now = tick();
        c.ts = 48'({$urandom, $urandom});
        c.spd = 16'($urandom);
        c.lp = 1'($urandom);
        c.seek = $urandom;
        c.drain = 0;
        if (c.fn == F_CLEAR) c.fn = F_QUERY;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic put_op();
        case ($urandom_range(9))
            0, 1: put(F_PLAY);
            2: put(F_PAUSE);
            3: put(F_SPEED, '0, ($urandom_range(9) == 0) ? 16'd0 :
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1024)));
            4: put(F_LOOP, '0, 16'd256, 1'($urandom));
            5: put(F_SEEK, '0, 16'd256, 0, ($urandom_range(3) == 0) ? $urandom :
                   $urandom_range(120000));
            default: put(F_QUERY);
        endcase
    endtask

    task automatic put_timeline(int n, bit sloppy);
        logic [47:0] ts;
        ts = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                                        48'($urandom_range(1000000));
        last_ts = ts;
        put(F_APPEND, ts);
        for (int k = 1; k < n; k++) begin
            if (sloppy && $urandom_range(7) == 0) begin
                case ($urandom_range(2))
                    0: put(F_APPEND, last_ts - 1 - $urandom_range(100));
                    1: put(F_APPEND, ts - 1);
                    default: put(F_APPEND, last_ts + 48'h8000_0000 + $urandom_range(9));
                endcase
            end else begin
                last_ts = last_ts + (($urandom_range(5) == 0) ? 0 : $urandom_range(1, 20000));
                put(F_APPEND, last_ts);
            end
        end
    endtask

    initial begin
        wall = 48'd1000;
        tl = '{default: '0};
        n_loaded = 0;
        first_ts = 0;
        running = 0;
        held = 0;
        anchor = 0;
        rate = RATE_RESET;
        wrap = 0;

        // directed
        put(F_QUERY);
        put(F_PLAY);
        put(F_PAUSE);
        put(F_SEEK, '0, 16'd256, 0, 32'd500);
        put(F_SPEED, '0, 16'd0);
        put(F_APPEND, 48'hFFFF_0000_0000);
        put(F_APPEND, 48'hFFFF_0000_0000 - 1);
        put(F_APPEND, 48'hFFFF_8000_0000);
        put(F_APPEND, 48'hFFFF_0000_0000);
        put(F_APPEND, 48'hFFFF_7FFF_FFFF);
        put(F_APPEND, 48'hFFFF_FFFF_FFFF);
        put(F_PLAY);
        put(F_PLAY);
        put(F_SPEED, '0, 16'hFFFF);
        put(F_LOOP, '0, 16'd256, 1);
        put(F_SEEK, '0, 16'd256, 0, 32'h8000_0000);
        put(F_SEEK, '0, 16'd256, 0, 32'h7FFF_FFFF);
        put(F_SPEED, '0, 16'd1);
        put(F_PAUSE);
        put(F_PAUSE);
        put(F_CLEAR, '0, 16'd256, 0, '0, 1);
        put(F_APPEND, 48'd0);
        put(F_PLAY);
        put(F_QUERY);
        put(F_LOOP, '0, 16'd256, 0);

        // random timelines with random playback traffic; one fills the table
        for (int seq = 0; seq < 6; seq++) begin
            put(F_CLEAR, '0, 16'd256, 0, '0, seq == 3);
            if (seq == 2) begin
                put_timeline(DEPTH, 0);
                put(F_APPEND, last_ts + 5);
                put(F_SEEK, '0, 16'd256, 0, $urandom_range(30000000));
                put(F_QUERY);
            end else begin
                put_timeline($urandom_range(1, 12), 1);
            end
            for (int k = $urandom_range(6, 16); k > 0; k--) begin
                if ($urandom_range(9) == 0) put_noise();
                else put_op();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (cmd_q.size() == 0 && !s_tvalid && status_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (status_q.size() != 0) begin
            report_mismatch("results never arrived", 64'(status_q.size()), 64'(0));
        end
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
